FILE: hdl/nfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfm_pkg
// Shared types, constants and helper functions of the NUT frame muxer.
// ----------------------------------------------------------------------------
package nfm_pkg;

    localparam int POSITION_BITS_DEF = 48;
    localparam int PTS_BITS_DEF      = 40;

    localparam logic [63:0] SYNC_STARTCODE = 64'h4E4B_E4AD_EECA_4569;
    localparam logic [31:0] CRC_POLY       = 32'h04C1_1DB7;
    localparam logic [63:0] FRAME_FLAGS    = 64'd4216;
    localparam int          MSB_PTS_SHIFT  = 7;
    localparam logic [20:0] SYNC_DIST_RST  = 21'd65536;
    localparam logic [4:0]  STREAM_CNT_RST = 5'd1;

    localparam logic CFG_STREAM_COUNT  = 1'b0;
    localparam logic CFG_SYNC_DISTANCE = 1'b1;

    // Output segment selected by the controller
    typedef enum logic [3:0] {
        SEG_CODE, SEG_FWD, SEG_TT, SEG_BACK, SEG_SCRC,
        SEG_FZERO, SEG_FLAGS, SEG_IDX, SEG_PTS, SEG_LEN, SEG_FCRC
    } seg_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_CODE, ST_FWD, ST_TT, ST_BACK, ST_SCRC,
        ST_FZERO, ST_FLAGS, ST_IDX, ST_PTS, ST_LEN, ST_FCRC
    } state_t;

    typedef struct packed {
        logic accept;   // input transaction taken this cycle
        logic emit;     // load one header byte into the output register
        logic mul;      // compute the syncpoint timestamp product
        logic last;     // emitted byte ends the transaction
        seg_t seg;
    } nfm_cmd_t;

    typedef struct packed {
        logic bad;       // stream index of the offered item is out of range
        logic need_sync; // offered header needs a syncpoint first
        logic seg_done;  // current byte is the final one of its segment
        logic slot_free; // output register can take a byte
    } nfm_status_t;

    // Number of 7-bit groups of a varint
    function automatic logic [3:0] vlen(input logic [63:0] v);
        logic [3:0] n;
        n = 4'd1;
        for (int i = 1; i < 10; i++)
        begin
            if ((v >> (7 * i)) != 64'd0)
                n = 4'(i + 1);
        end
        return n;
    endfunction

    function automatic logic [6:0] vgroup(input logic [63:0] v, input logic [3:0] g);
        logic [69:0] w;
        logic [6:0]  r;
        w = {6'd0, v};
        r = 7'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (g == 4'(i))
                r = w[7*i +: 7];
        end
        return r;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {b, 24'd0};
        for (int k = 0; k < 8; k++)
            r = {r[30:0], 1'b0} ^ (r[31] ? CRC_POLY : 32'd0);
        return r;
    endfunction

endpackage

FILE: hdl/nfm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfm_ctrl
// Sequencer that steps through syncpoint and frame header segments.
// ----------------------------------------------------------------------------
module nfm_ctrl
    import nfm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        action,
    input  nfm_status_t status,
    output logic        in_stall,
    output nfm_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.slot_free && !action && !status.bad)
                    state_next = status.need_sync ? ST_MUL : ST_FZERO;
            end
            ST_MUL:   state_next = ST_CODE;
            ST_CODE:  if (status.slot_free && status.seg_done) state_next = ST_FWD;
            ST_FWD:   if (status.slot_free && status.seg_done) state_next = ST_TT;
            ST_TT:    if (status.slot_free && status.seg_done) state_next = ST_BACK;
            ST_BACK:  if (status.slot_free && status.seg_done) state_next = ST_SCRC;
            ST_SCRC:  if (status.slot_free && status.seg_done) state_next = ST_FZERO;
            ST_FZERO: if (status.slot_free && status.seg_done) state_next = ST_FLAGS;
            ST_FLAGS: if (status.slot_free && status.seg_done) state_next = ST_IDX;
            ST_IDX:   if (status.slot_free && status.seg_done) state_next = ST_PTS;
            ST_PTS:   if (status.slot_free && status.seg_done) state_next = ST_LEN;
            ST_LEN:   if (status.slot_free && status.seg_done) state_next = ST_FCRC;
            ST_FCRC:  if (status.slot_free && status.seg_done) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.accept = 1'b0;
        cmd.emit   = 1'b0;
        cmd.mul    = 1'b0;
        cmd.last   = 1'b0;
        cmd.seg    = SEG_FZERO;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = !status.slot_free;
                cmd.accept = in_valid && status.slot_free;
            end
            ST_MUL:   cmd.mul = 1'b1;
            ST_CODE:  cmd.seg = SEG_CODE;
            ST_FWD:   cmd.seg = SEG_FWD;
            ST_TT:    cmd.seg = SEG_TT;
            ST_BACK:  cmd.seg = SEG_BACK;
            ST_SCRC:  cmd.seg = SEG_SCRC;
            ST_FZERO: cmd.seg = SEG_FZERO;
            ST_FLAGS: cmd.seg = SEG_FLAGS;
            ST_IDX:   cmd.seg = SEG_IDX;
            ST_PTS:   cmd.seg = SEG_PTS;
            ST_LEN:   cmd.seg = SEG_LEN;
            ST_FCRC:
            begin
                cmd.seg  = SEG_FCRC;
                cmd.last = status.seg_done;
            end
            default:  cmd.seg = SEG_FZERO;
        endcase
        if (state_reg != ST_IDLE && state_reg != ST_MUL)
            cmd.emit = status.slot_free;
    end

endmodule

FILE: hdl/nfm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfm_datapath
// Configuration, stream position, varint and CRC generation, output register.
// ----------------------------------------------------------------------------
module nfm_datapath
    import nfm_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int PTS_BITS      = PTS_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic                cfg_index,
    input  logic [20:0]         cfg_data,
    input  logic                action,
    input  logic [3:0]          stream_id,
    input  logic [PTS_BITS-1:0] pts,
    input  logic                keyframe,
    input  logic [31:0]         frame_length,
    input  logic [7:0]          data_byte,
    input  nfm_cmd_t            cmd,
    output nfm_status_t         status,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_byte,
    output logic                last,
    output logic                bad_stream
);

    logic [4:0]               stream_count_reg;
    logic [20:0]              sync_distance_reg;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] last_sync_reg;
    logic                     sync_seen_reg;
    logic [3:0]               idx_reg;
    logic [PTS_BITS-1:0]      pts_reg;
    logic                     key_reg;
    logic [31:0]              len_reg;
    logic [63:0]              back_reg;
    logic [63:0]              tt_reg;
    logic [31:0]              crc_reg;
    logic [3:0]               cnt_reg;
    logic                     out_valid_reg;
    logic [7:0]               out_byte_reg;
    logic                     last_reg;
    logic                     bad_reg;

    logic [POSITION_BITS-1:0] sync_gap;
    logic [63:0]              vval;
    logic [3:0]               seg_len;
    logic [7:0]               hdr_byte;
    logic [31:0]              crc_base;
    logic                     load;

    assign sync_gap         = pos_reg - last_sync_reg;
    assign status.slot_free = !out_valid_reg || !out_stall;
    assign status.bad       = {1'b0, stream_id} >= stream_count_reg;
    assign status.need_sync = !sync_seen_reg
                              || sync_gap >= POSITION_BITS'(sync_distance_reg);
    assign status.seg_done  = cnt_reg == seg_len - 4'd1;

    always_comb
    begin
        unique case (cmd.seg)
            SEG_FWD:   vval = 64'(vlen(tt_reg)) + 64'(vlen(back_reg)) + 64'd4;
            SEG_TT:    vval = tt_reg;
            SEG_BACK:  vval = back_reg;
            SEG_FLAGS: vval = FRAME_FLAGS | 64'(key_reg);
            SEG_IDX:   vval = 64'(idx_reg);
            SEG_PTS:   vval = 64'(pts_reg) + (64'd1 << MSB_PTS_SHIFT);
            SEG_LEN:   vval = 64'(len_reg);
            default:   vval = 64'd0;
        endcase
    end

    always_comb
    begin
        unique case (cmd.seg)
            SEG_CODE:
            begin
                seg_len  = 4'd8;
                hdr_byte = SYNC_STARTCODE[8*(7 - cnt_reg[2:0]) +: 8];
            end
            SEG_SCRC, SEG_FCRC:
            begin
                seg_len  = 4'd4;
                hdr_byte = crc_reg[8*cnt_reg[1:0] +: 8];
            end
            SEG_FZERO:
            begin
                seg_len  = 4'd1;
                hdr_byte = 8'd0;
            end
            default:
            begin
                seg_len  = vlen(vval);
                hdr_byte = {cnt_reg != seg_len - 4'd1,
                            vgroup(vval, seg_len - 4'd1 - cnt_reg)};
            end
        endcase
    end

    // restart the checksum where the syncpoint body and the frame header begin
    assign crc_base = ((cmd.seg == SEG_TT && cnt_reg == 4'd0) || cmd.seg == SEG_FZERO)
                      ? 32'd0 : crc_reg;

    // a good header request emits nothing itself; its bytes follow from the controller
    assign load = (cmd.accept && action) || cmd.emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_count_reg  <= STREAM_CNT_RST;
            sync_distance_reg <= SYNC_DIST_RST;
            pos_reg           <= '0;
            last_sync_reg     <= '0;
            sync_seen_reg     <= 1'b0;
            cnt_reg           <= 4'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                unique case (cfg_index)
                    CFG_STREAM_COUNT:  stream_count_reg  <= cfg_data[4:0];
                    CFG_SYNC_DISTANCE: sync_distance_reg <= cfg_data;
                    default:           stream_count_reg  <= stream_count_reg;
                endcase
            end
            if (load)
                pos_reg <= pos_reg + POSITION_BITS'(1);
            if (cmd.accept && !action && !status.bad && status.need_sync)
            begin
                last_sync_reg <= pos_reg;
                sync_seen_reg <= 1'b1;
            end
            if (cmd.emit)
                cnt_reg <= status.seg_done ? 4'd0 : cnt_reg + 4'd1;
            if (status.slot_free)
                out_valid_reg <= (cmd.accept && (action || status.bad)) || cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && !action && !status.bad)
        begin
            idx_reg  <= stream_id;
            pts_reg  <= pts;
            key_reg  <= keyframe;
            len_reg  <= frame_length;
            back_reg <= sync_seen_reg ? 64'(sync_gap >> 4) : 64'd0;
        end
        if (cmd.mul)
            tt_reg <= 64'(pts_reg) * 64'(stream_count_reg) + 64'(idx_reg);
        if (cmd.emit && cmd.seg != SEG_SCRC && cmd.seg != SEG_FCRC)
            crc_reg <= crc_byte(crc_base, hdr_byte);
        if (cmd.accept)
        begin
            out_byte_reg <= action ? data_byte : 8'd0;
            last_reg     <= 1'b1;
            bad_reg      <= !action;
        end
        else if (cmd.emit)
        begin
            out_byte_reg <= hdr_byte;
            last_reg     <= cmd.last;
            bad_reg      <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign last       = last_reg;
    assign bad_stream = bad_reg;

endmodule

FILE: hdl/nut_frame_muxer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nut_frame_muxer_core
// NUT frame muxer: frame headers, syncpoints and payload pass-through.
// ----------------------------------------------------------------------------
// A payload byte streams at one byte per cycle while the output is not stalled. A
// bad stream index gives a single error transaction. A frame header emits 11 to
// 19 bytes, and a header preceded by a syncpoint adds the syncpoint bytes (15 to
// 27) and a state for the timestamp multiply; the controller emits one byte per
// cycle through a single output register while the output is not stalled, and
// no input is taken until the header run has finished.
module nut_frame_muxer_core
    import nfm_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int PTS_BITS      = PTS_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic                cfg_index,
    input  logic [20:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                action,
    input  logic [3:0]          stream_id,
    input  logic [PTS_BITS-1:0] pts,
    input  logic                keyframe,
    input  logic [31:0]         frame_length,
    input  logic [7:0]          data_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_byte,
    output logic                last,
    output logic                bad_stream
);

    nfm_cmd_t    cmd;
    nfm_status_t status;

    nfm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    nfm_datapath #(
        .POSITION_BITS (POSITION_BITS),
        .PTS_BITS      (PTS_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .action       (action),
        .stream_id    (stream_id),
        .pts          (pts),
        .keyframe     (keyframe),
        .frame_length (frame_length),
        .data_byte    (data_byte),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .last         (last),
        .bad_stream   (bad_stream)
    );

endmodule

FILE: hdl/nfm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfm_checker
// Port-level assertions for the NUT frame muxer, bound to the top level.
// ----------------------------------------------------------------------------
module nfm_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       action,
    input logic [7:0] data_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       last,
    input logic       bad_stream
);

    // a new transaction never lands on a blocked output byte
    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> !(out_valid && out_stall))
        else $error("input taken while output blocked");

    a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_stream |-> last && out_byte == 8'd0)
        else $error("malformed error result");

    a_payload_pass: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && action |=>
        out_valid && last && !bad_stream && out_byte == $past(data_byte))
        else $error("payload byte not passed through");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("stalled output changed");

endmodule

bind nut_frame_muxer_core nfm_checker u_nfm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .last       (last),
    .bad_stream (bad_stream)
);

FILE: tb/sv/nut_frame_muxer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nut_frame_muxer_core_tb
// Self-checking bench for the NUT frame muxer: syncpoints, frame headers,
// payload pass-through and bad stream errors, under random output stalls, random
// input gaps and several register settings.
// ----------------------------------------------------------------------------
module nut_frame_muxer_core_tb;
    import nfm_pkg::*;

    localparam int   WATCHDOG_LIMIT = 20000;
    localparam logic PAYLOAD_BYTE   = 1'b1;
    localparam logic HEADER_REQ     = 1'b0;

    typedef struct packed {
        logic [7:0] data;
        logic       eot;
        logic       bad;
    } mux_byte_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wen;
    logic        cfg_index;
    logic [20:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [3:0]  stream_id;
    logic [39:0] pts;
    logic        keyframe;
    logic [31:0] frame_length;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic        last;
    logic        bad_stream;

    // predictor state
    logic [4:0]  pr_streams;
    logic [20:0] pr_sync_dist;
    logic [47:0] pr_pos;
    logic [47:0] pr_sync_pos;
    logic        pr_synced;
    logic [31:0] pr_crc;

    mux_byte_t   expected_bytes[$];
    int          error_count;
    int          byte_count;
    int          frame_count;
    int          sync_count;
    int          idle_cycles;
    bit          stall_enable;

    nut_frame_muxer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .stream_id    (stream_id),
        .pts          (pts),
        .keyframe     (keyframe),
        .frame_length (frame_length),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .last         (last),
        .bad_stream   (bad_stream)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic int groups7(input logic [63:0] v);
        int n;
        n = 1;
        v = v >> 7;
        while (v != 64'd0)
        begin
            n++;
            v = v >> 7;
        end
        return n;
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        mux_byte_t e;
        e.data = b;
        e.eot  = 1'b0;
        e.bad  = 1'b0;
        expected_bytes.push_back(e);
        pr_pos = pr_pos + 48'd1;
        pr_crc = pr_crc ^ {b, 24'd0};
        for (int k = 0; k < 8; k++)
            pr_crc = {pr_crc[30:0], 1'b0} ^ (pr_crc[31] ? 32'h04C1_1DB7 : 32'd0);
    endfunction

    function automatic void push_varint(input logic [63:0] v);
        int g;
        g = groups7(v);
        while (g > 0)
        begin
            g--;
            push_byte({(g != 0), 7'((v >> (7 * g)) & 64'h7F)});
        end
    endfunction

    function automatic void push_crc();
        logic [31:0] c;
        c = pr_crc;
        for (int i = 0; i < 4; i++)
            push_byte(c[8*i +: 8]);
    endfunction

    // Append the bytes one transaction should produce.
    function automatic void predict_mux(input logic act, input logic [3:0] idx,
                                        input logic [39:0] ts, input logic key,
                                        input logic [31:0] len, input logic [7:0] db);
        mux_byte_t   e;
        logic [63:0] tt;
        logic [63:0] back;
        logic [47:0] here;
        pr_crc = 32'd0;
        if (act == 1'b1)
        begin
            push_byte(db);
        end
        else if ({1'b0, idx} >= pr_streams)
        begin
            e.data = 8'd0;
            e.eot  = 1'b1;
            e.bad  = 1'b1;
            expected_bytes.push_back(e);
            return;
        end
        else
        begin
            if (!pr_synced || (pr_pos - pr_sync_pos) >= {27'd0, pr_sync_dist})
            begin
                here = pr_pos;
                tt   = {24'd0, ts} * {59'd0, pr_streams} + {60'd0, idx};
                back = pr_synced ? {16'd0, (here - pr_sync_pos) >> 4} : 64'd0;
                for (int k = 0; k < 8; k++)
                    push_byte(SYNC_STARTCODE[63 - 8 * k -: 8]);
                push_varint(64'(groups7(tt) + groups7(back) + 4));
                pr_crc = 32'd0;
                push_varint(tt);
                push_varint(back);
                push_crc();
                pr_sync_pos = here;
                pr_synced   = 1'b1;
                sync_count++;
            end
            pr_crc = 32'd0;
            push_byte(8'd0);
            push_varint(FRAME_FLAGS | {63'd0, key});
            push_varint({60'd0, idx});
            push_varint({24'd0, ts} + 64'd128);
            push_varint({32'd0, len});
            push_crc();
            frame_count++;
        end
        e = expected_bytes.pop_back();
        e.eot = 1'b1;
        expected_bytes.push_back(e);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %0t: %s got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Check each output transaction against the oldest expected byte.
    always @(posedge clk)
    begin
        mux_byte_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            byte_count++;
            if (expected_bytes.size() == 0)
            begin
                report_mismatch("unexpected byte", out_byte, 0);
            end
            else
            begin
                e = expected_bytes.pop_front();
                if (out_byte !== e.data)
                    report_mismatch("out_byte", out_byte, e.data);
                if (last !== e.eot)
                    report_mismatch("last", last, e.eot);
                if (bad_stream !== e.bad)
                    report_mismatch("bad_stream", bad_stream, e.bad);
            end
        end
    end

    // Random backpressure on the output side.
    always
    begin
        int n;
        @(negedge clk);
        if (stall_enable && $urandom_range(0, 99) < 30)
        begin
            n = gap_len();
            out_stall <= 1'b1;
            repeat (n > 0 ? n : 1) @(negedge clk);
        end
        out_stall <= 1'b0;
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog timeout at %0t", $realtime);
            $display("Some tests failed");
            $finish;
        end
    end

    // Entered and left at a falling edge; valid stays high into a back-to-back item.
    task automatic send_item(input logic act, input logic [3:0] idx,
                             input logic [39:0] ts, input logic key,
                             input logic [31:0] len, input logic [7:0] db,
                             input bit gaps);
        int n;
        n = gaps ? gap_len() : 0;
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        stream_id    <= idx;
        pts          <= ts;
        keyframe     <= key;
        frame_length <= len;
        data_byte    <= db;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_mux(act, idx, ts, key, len, db);
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [3:0] idx, input int nbytes, input bit gaps);
        logic [39:0] ts;
        ts = 40'({$urandom, $urandom});
        if ($urandom_range(0, 3) == 0)
            ts = 40'($urandom_range(0, 300));
        send_item(HEADER_REQ, idx, ts, 1'($urandom), 32'(nbytes), 8'd0, gaps);
        for (int i = 0; i < nbytes; i++)
            send_item(PAYLOAD_BYTE, 4'($urandom), 40'($urandom), 1'($urandom), $urandom,
                      8'($urandom), gaps);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [20:0] val);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wen <= 1'b0;
        if (idx == CFG_STREAM_COUNT)
            pr_streams = val[4:0];
        else
            pr_sync_dist = val;
    endtask

    task automatic test_directed();
        // first frame after reset forces a syncpoint with zero back pointer
        send_item(HEADER_REQ, 4'd0, 40'd0, 1'b1, 32'd0, 8'd0, 1'b0);
        send_item(HEADER_REQ, 4'd1, 40'd5, 1'b0, 32'd3, 8'd0, 1'b0);
        send_item(PAYLOAD_BYTE, 4'd0, 40'd0, 1'b0, 32'd0, 8'hFF, 1'b0);
        send_item(PAYLOAD_BYTE, 4'hF, 40'hFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 8'h00, 1'b0);
        send_item(HEADER_REQ, 4'd0, 40'hFF_FFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 8'd0, 1'b0);
        wait_drained();
        write_reg(CFG_STREAM_COUNT, 21'd16);
        write_reg(CFG_SYNC_DISTANCE, 21'd0);
        send_item(HEADER_REQ, 4'hF, 40'hFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 8'd0, 1'b0);
        send_item(HEADER_REQ, 4'd0, 40'd127, 1'b0, 32'd127, 8'd0, 1'b0);
        send_item(HEADER_REQ, 4'd7, 40'h80_0000_0000, 1'b1, 32'd128, 8'd0, 1'b0);
        wait_drained();
        write_reg(CFG_STREAM_COUNT, 21'd0);
        send_item(HEADER_REQ, 4'd0, 40'd9, 1'b1, 32'd1, 8'd0, 1'b0);
        send_item(PAYLOAD_BYTE, 4'd0, 40'd0, 1'b0, 32'd0, 8'h5A, 1'b0);
        wait_drained();
        write_reg(CFG_STREAM_COUNT, 21'd31);
        write_reg(CFG_SYNC_DISTANCE, 21'h1F_FFFF);
        send_item(HEADER_REQ, 4'hF, 40'd1000, 1'b0, 32'd2, 8'd0, 1'b0);
        send_item(PAYLOAD_BYTE, 4'd0, 40'd0, 1'b0, 32'd0, 8'hA5, 1'b0);
        wait_drained();
    endtask

    task automatic test_random(input logic [4:0] streams, input logic [20:0] sync_dist,
                               input int items);
        int sent;
        int n;
        logic [3:0] idx;
        write_reg(CFG_STREAM_COUNT, {16'd0, streams});
        write_reg(CFG_SYNC_DISTANCE, sync_dist);
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // random header request (the stream index may be bad) or stray payload byte
                idx = 4'($urandom_range(0, 15));
                send_item(1'($urandom), idx, 40'({$urandom, $urandom}), 1'($urandom),
                          $urandom, 8'($urandom), 1'b1);
                sent++;
            end
            else
            begin
                n = $urandom_range(0, 6);
                idx = (streams == 0) ? 4'd0 :
                      4'($urandom_range(0, (streams > 16 ? 16 : streams) - 1));
                send_frame(idx, n, 1'b1);
                sent += n + 1;
            end
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_wen      = 1'b0;
        cfg_index    = 1'b0;
        cfg_data     = 21'd0;
        in_valid     = 1'b0;
        action       = 1'b0;
        stream_id    = 4'd0;
        pts          = 40'd0;
        keyframe     = 1'b0;
        frame_length = 32'd0;
        data_byte    = 8'd0;
        out_stall    = 1'b0;
        stall_enable = 1'b0;
        error_count  = 0;
        byte_count   = 0;
        frame_count  = 0;
        sync_count   = 0;
        idle_cycles  = 0;
        pr_streams   = STREAM_CNT_RST;
        pr_sync_dist = SYNC_DIST_RST;
        pr_pos       = 48'd0;
        pr_sync_pos  = 48'd0;
        pr_synced    = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        stall_enable = 1'b1;
        test_random(5'd4, 21'd40, 90);
        test_random(5'd16, 21'd1, 80);
        test_random(5'd3, 21'd0, 60);
        stall_enable = 1'b0;
        test_random(5'd9, 21'd150, 60);
        stall_enable = 1'b1;
        test_random(5'd1, 21'h1F_FFFF, 40);

        $display("Covered %0d frame headers, %0d syncpoints, %0d output bytes",
                 frame_count, sync_count, byte_count);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: nut_frame_muxer_core.f
hdl/nfm_pkg.sv
hdl/nfm_ctrl.sv
hdl/nfm_datapath.sv
hdl/nut_frame_muxer_core.sv
hdl/nfm_checker.sv
tb/sv/nut_frame_muxer_core_tb.sv
